// ===== hw/rtl/bsm_pkg.sv =====
package bsm_pkg;

  // Coordinate and derived widths
  localparam int CW    = 32;          // signed center coordinate
  localparam int RW    = CW - 1;      // unsigned radius
  localparam int MW    = CW + 1;      // magnitude of a center difference
  localparam int DW    = CW + 2;      // center distance (integer square root)
  localparam int SW    = 2 * DW;      // sum of squared differences
  localparam int PW    = MW + DW;     // magnitude times radius offset
  localparam int AXES  = 3;

  // Result case codes
  localparam logic [1:0] CASE_A   = 2'd0;
  localparam logic [1:0] CASE_B   = 2'd1;
  localparam logic [1:0] CASE_NEW = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] a_center_x;
    logic signed [CW-1:0] a_center_y;
    logic signed [CW-1:0] a_center_z;
    logic        [RW-1:0] a_radius;
    logic signed [CW-1:0] b_center_x;
    logic signed [CW-1:0] b_center_y;
    logic signed [CW-1:0] b_center_z;
    logic        [RW-1:0] b_radius;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] merged_x;
    logic signed [CW-1:0] merged_y;
    logic signed [CW-1:0] merged_z;
    logic        [RW-1:0] merged_radius;
    logic        [1:0]    which_case;
    logic                 saturated;
  } out_word_t;

  // Geometry carried alongside the distance computation
  typedef struct packed {
    logic [AXES-1:0][CW-1:0] ac;
    logic [AXES-1:0][CW-1:0] bc;
    logic [AXES-1:0][MW-1:0] mag;
    logic [AXES-1:0]         neg;
    logic [RW-1:0]           ra;
    logic [RW-1:0]           rb;
  } geo_t;

  // Context carried alongside the center division
  typedef struct packed {
    logic [AXES-1:0][CW-1:0] ac;
    logic [AXES-1:0][CW-1:0] bc;
    logic [AXES-1:0]         neg;
    logic [RW-1:0]           ra;
    logic [RW-1:0]           rb;
    logic [DW-1:0]           rad;
    logic [1:0]              kase;
  } post_t;

endpackage

// ===== hw/rtl/bsm_isqrt.sv =====
module bsm_isqrt
  import bsm_pkg::*;
#(
  parameter int ROOT_W = DW,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int REM_W = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              v_q    [ROOT_W];

  // One root bit per stage
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [RAD_W-1:0]  cur_rad;
    logic [SIDE_W-1:0] cur_side;
    logic              cur_v;
    logic [REM_W-1:0]  cat;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (i == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = radicand;
      assign cur_side = side_in;
      assign cur_v    = in_valid;
    end else begin : g_next
      assign cur_rem  = rem_q[i-1];
      assign cur_root = root_q[i-1];
      assign cur_rad  = rad_q[i-1];
      assign cur_side = side_q[i-1];
      assign cur_v    = v_q[i-1];
    end

    assign cat   = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
    assign trial = {cur_root, 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= take ? (cat - trial) : cat;
        root_q[i] <= {cur_root[ROOT_W-2:0], take};
        rad_q[i]  <= {cur_rad[RAD_W-3:0], 2'b00};
        side_q[i] <= cur_side;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign side_out  = side_q[ROOT_W-1];

endmodule

// ===== hw/rtl/bsm_udiv.sv =====
module bsm_udiv
  import bsm_pkg::*;
#(
  parameter int DEN_W  = DW,
  parameter int QW     = MW,
  parameter int LANES  = AXES,
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][DEN_W+QW-1:0] num,
  input  logic [DEN_W-1:0]               den,
  input  logic [SIDE_W-1:0]              side_in,
  output logic                           out_valid,
  output logic [LANES-1:0][QW-1:0]       quo,
  output logic [SIDE_W-1:0]              side_out
);

  localparam int NW = DEN_W + QW;

  logic [LANES-1:0][DEN_W-1:0] r_q   [QW];
  logic [LANES-1:0][QW-1:0]    lo_q  [QW];
  logic [LANES-1:0][QW-1:0]    q_q   [QW];
  logic [DEN_W-1:0]            den_q [QW];
  logic [SIDE_W-1:0]           side_q[QW];
  logic                        v_q   [QW];

  // One quotient bit per stage; the quotient is known to fit in QW bits,
  // so the upper numerator part starts below the divisor.
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] cur_r;
    logic [LANES-1:0][QW-1:0]    cur_lo;
    logic [LANES-1:0][QW-1:0]    cur_q;
    logic [DEN_W-1:0]            cur_den;
    logic [SIDE_W-1:0]           cur_side;
    logic                        cur_v;
    logic [LANES-1:0][DEN_W-1:0] r_next;
    logic [LANES-1:0][QW-1:0]    q_next;

    if (i == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign cur_r[l]  = num[l][NW-1:QW];
        assign cur_lo[l] = num[l][QW-1:0];
      end
      assign cur_q    = '0;
      assign cur_den  = den;
      assign cur_side = side_in;
      assign cur_v    = in_valid;
    end else begin : g_next
      assign cur_r    = r_q[i-1];
      assign cur_lo   = lo_q[i-1];
      assign cur_q    = q_q[i-1];
      assign cur_den  = den_q[i-1];
      assign cur_side = side_q[i-1];
      assign cur_v    = v_q[i-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] r2;
      logic [DEN_W:0] diff;
      logic           ge;
      assign r2   = {cur_r[l], cur_lo[l][QW-1]};
      assign diff = r2 - {1'b0, cur_den};
      assign ge   = (r2 >= {1'b0, cur_den});
      assign r_next[l] = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      assign q_next[l] = {cur_q[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[i]    <= r_next;
        q_q[i]    <= q_next;
        den_q[i]  <= cur_den;
        side_q[i] <= cur_side;
        for (int l = 0; l < LANES; l++) begin
          lo_q[i][l] <= {cur_lo[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign quo       = q_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule

// ===== hw/rtl/bounding_sphere_merge_unit.sv =====
// Stages from an accepted input word to its result word
// (4 front stages, 34 square-root stages, 2 middle stages, 33 divide stages,
// 1 output register). Throughput: one word per cycle; the whole pipeline
// holds while the output word is stalled.
// Reset: rst, synchronous and active high, clears every stage valid bit.
module bounding_sphere_merge_unit
  import bsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result
);

  localparam int GEO_W  = $bits(geo_t);
  localparam int POST_W = $bits(post_t);

  // Global advance: every stage moves unless the output word is held.
  // Hold off the input while reset clears the valid bits.
  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en || rst;

  // ---------------------------------------------------------------------
  // Stage 0: capture the input word
  // ---------------------------------------------------------------------
  logic     v0;
  in_word_t w0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0 <= item;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: center differences, split into sign and magnitude
  // ---------------------------------------------------------------------
  logic [AXES-1:0][CW-1:0] ac0, bc0;
  assign ac0 = {w0.a_center_z, w0.a_center_y, w0.a_center_x};
  assign bc0 = {w0.b_center_z, w0.b_center_y, w0.b_center_x};

  geo_t g1_next, g1;
  logic v1;

  always_comb begin
    logic [MW-1:0] d;
    g1_next.ac = ac0;
    g1_next.bc = bc0;
    g1_next.ra = w0.a_radius;
    g1_next.rb = w0.b_radius;
    for (int i = 0; i < AXES; i++) begin
      d = {bc0[i][CW-1], bc0[i]} - {ac0[i][CW-1], ac0[i]};
      g1_next.neg[i] = d[MW-1];
      g1_next.mag[i] = d[MW-1] ? (~d + 1'b1) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= g1_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: square each magnitude (one multiplier per axis)
  // ---------------------------------------------------------------------
  logic [AXES-1:0][2*MW-1:0] sq2;
  geo_t g2;
  logic v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2 <= g1;
      for (int i = 0; i < AXES; i++) begin
        sq2[i] <= g1.mag[i] * g1.mag[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: sum of squares, exact
  // ---------------------------------------------------------------------
  logic [SW-1:0] s3;
  geo_t          g3;
  logic          v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g3 <= g2;
      s3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Floor square root of the sum: center distance
  // ---------------------------------------------------------------------
  logic [DW-1:0]    dist4;
  logic [GEO_W-1:0] g4_bits;
  geo_t             g4;
  logic             v4;

  bsm_isqrt #(
    .ROOT_W (DW),
    .SIDE_W (GEO_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .radicand  (s3),
    .side_in   (g3),
    .out_valid (v4),
    .root      (dist4),
    .side_out  (g4_bits)
  );

  assign g4 = geo_t'(g4_bits);

  // ---------------------------------------------------------------------
  // Stage 5: containment tests, new radius and center offset
  // ---------------------------------------------------------------------
  logic [DW:0]   sum_b, sum_a, sum_all;
  logic [DW-1:0] rad_c;
  post_t         p5_next, p5;
  logic [DW-1:0] k5, dist5;
  logic [AXES-1:0][MW-1:0] mag5;
  logic          v5;

  assign sum_b   = {1'b0, dist4} + (DW+1)'(g4.rb);
  assign sum_a   = {1'b0, dist4} + (DW+1)'(g4.ra);
  assign sum_all = sum_a + (DW+1)'(g4.rb);
  assign rad_c   = sum_all[DW:1];

  always_comb begin
    p5_next.ac  = g4.ac;
    p5_next.bc  = g4.bc;
    p5_next.neg = g4.neg;
    p5_next.ra  = g4.ra;
    p5_next.rb  = g4.rb;
    p5_next.rad = rad_c;
    // b inside a wins over a inside b, which covers equal spheres
    if (sum_b <= (DW+1)'(g4.ra)) begin
      p5_next.kase = CASE_A;
    end else if (sum_a <= (DW+1)'(g4.rb)) begin
      p5_next.kase = CASE_B;
    end else begin
      p5_next.kase = CASE_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5    <= p5_next;
      k5    <= rad_c - DW'(g4.ra);
      dist5 <= dist4;
      mag5  <= g4.mag;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: magnitude times offset, per axis
  // ---------------------------------------------------------------------
  logic [AXES-1:0][PW-1:0] prod6;
  post_t         p6;
  logic [DW-1:0] dist6;
  logic          v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6    <= p5;
      dist6 <= dist5;
      for (int i = 0; i < AXES; i++) begin
        prod6[i] <= mag5[i] * k5;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide by the distance; the quotient stays below the magnitude.
  // Outside the new-sphere case the quotient is ignored.
  // ---------------------------------------------------------------------
  logic [AXES-1:0][MW-1:0] q7;
  logic [POST_W-1:0]       p7_bits;
  post_t                   p7;
  logic                    v7;

  bsm_udiv #(
    .DEN_W  (DW),
    .QW     (MW),
    .LANES  (AXES),
    .SIDE_W (POST_W)
  ) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .num       (prod6),
    .den       (dist6),
    .side_in   (p6),
    .out_valid (v7),
    .quo       (q7),
    .side_out  (p7_bits)
  );

  assign p7 = post_t'(p7_bits);

  // ---------------------------------------------------------------------
  // Output stage: apply offsets, clamp, pick the case
  // ---------------------------------------------------------------------
  out_word_t               res_next;
  logic [AXES-1:0][CW-1:0] cn;
  logic [AXES-1:0]         csat;
  logic [RW-1:0]           rn;
  logic                    rsat;

  always_comb begin
    logic [CW+1:0] s;
    for (int i = 0; i < AXES; i++) begin
      s = p7.neg[i] ? ({{2{p7.ac[i][CW-1]}}, p7.ac[i]} - {1'b0, q7[i]})
                    : ({{2{p7.ac[i][CW-1]}}, p7.ac[i]} + {1'b0, q7[i]});
      // In range only if the top three bits agree
      csat[i] = !((s[CW+1:CW-1] == 3'b000) || (s[CW+1:CW-1] == 3'b111));
      if (!csat[i]) begin
        cn[i] = s[CW-1:0];
      end else if (s[CW+1]) begin
        cn[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        cn[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    rsat = |p7.rad[DW-1:RW];
    rn   = rsat ? {RW{1'b1}} : p7.rad[RW-1:0];
  end

  always_comb begin
    case (p7.kase)
      CASE_A: begin
        res_next.merged_x      = p7.ac[0];
        res_next.merged_y      = p7.ac[1];
        res_next.merged_z      = p7.ac[2];
        res_next.merged_radius = p7.ra;
        res_next.saturated     = 1'b0;
      end
      CASE_B: begin
        res_next.merged_x      = p7.bc[0];
        res_next.merged_y      = p7.bc[1];
        res_next.merged_z      = p7.bc[2];
        res_next.merged_radius = p7.rb;
        res_next.saturated     = 1'b0;
      end
      default: begin
        res_next.merged_x      = cn[0];
        res_next.merged_y      = cn[1];
        res_next.merged_z      = cn[2];
        res_next.merged_radius = rn;
        res_next.saturated     = rsat || (|csat);
      end
    endcase
    res_next.which_case = p7.kase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// ===== sim/tb_bounding_sphere_merge_unit.sv =====
`timescale 1ns / 100ps

module tb_bounding_sphere_merge_unit;
  import bsm_pkg::*;

  localparam int RANDOM_WORDS = 900;
  localparam int LATENCY      = 74;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0]        RMAX = {RW{1'b1}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result;

  bounding_sphere_merge_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Spheres waiting for their merged word, oldest first
  out_word_t pending_spheres[$];
  int        mismatches;
  int        words_checked;
  int        case_seen[3];
  int        sat_seen;
  bit        sending_done;
  bit        hold_off_done;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("  bad %s in merged word %0d: got %0d want %0d", what, words_checked, got, want);
    mismatches++;
  endtask

  // Integer square root of a value up to SW bits, bit by bit
  function automatic logic [DW-1:0] isqrt(input logic [SW-1:0] v);
    logic [DW-1:0] r;
    logic [DW-1:0] t;
    r = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      t = r | (DW'(1) << b);
      if ({{SW-DW{1'b0}}, t} * {{SW-DW{1'b0}}, t} <= v) r = t;
    end
    return r;
  endfunction

  // Predict the enclosing sphere of two input spheres
  function automatic out_word_t merge_spheres(input in_word_t w);
    out_word_t                o;
    logic signed [CW+1:0]     ac[3];
    logic signed [CW+1:0]     bc[3];
    logic signed [CW+1:0]     d[3];
    logic        [MW-1:0]     mag[3];
    logic        [SW-1:0]     sq_sum;
    logic        [DW-1:0]     span;
    logic        [DW+1:0]     ra, rb, rad, k;
    logic        [PW+1:0]     q;
    logic signed [PW+3:0]     c;
    ac[0] = w.a_center_x; ac[1] = w.a_center_y; ac[2] = w.a_center_z;
    bc[0] = w.b_center_x; bc[1] = w.b_center_y; bc[2] = w.b_center_z;
    ra = w.a_radius;
    rb = w.b_radius;
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = bc[i] - ac[i];
      mag[i] = d[i] < 0 ? MW'(-d[i]) : MW'(d[i]);
      sq_sum += SW'(mag[i]) * SW'(mag[i]);
    end
    span = isqrt(sq_sum);
    o = '0;
    if (span + rb <= ra) begin
      o.merged_x = w.a_center_x; o.merged_y = w.a_center_y; o.merged_z = w.a_center_z;
      o.merged_radius = w.a_radius;
      o.which_case = CASE_A;
    end else if (span + ra <= rb) begin
      o.merged_x = w.b_center_x; o.merged_y = w.b_center_y; o.merged_z = w.b_center_z;
      o.merged_radius = w.b_radius;
      o.which_case = CASE_B;
    end else begin
      rad = (span + ra + rb) >> 1;
      k = rad - ra;
      for (int i = 0; i < 3; i++) begin
        q = ((PW+2)'(mag[i]) * (PW+2)'(k)) / (PW+2)'(span);
        c = d[i] < 0 ? (PW+4)'(ac[i]) - $signed({2'b00, q})
                     : (PW+4)'(ac[i]) + $signed({2'b00, q});
        if (c > CMAX) begin c = CMAX; o.saturated = 1'b1; end
        if (c < CMIN) begin c = CMIN; o.saturated = 1'b1; end
        case (i)
          0: o.merged_x = CW'(c);
          1: o.merged_y = CW'(c);
          default: o.merged_z = CW'(c);
        endcase
      end
      if (rad > RMAX) begin
        rad = RMAX;
        o.saturated = 1'b1;
      end
      o.merged_radius = RW'(rad);
      o.which_case = CASE_NEW;
    end
    return o;
  endfunction

  function automatic in_word_t sphere_pair(
    input logic signed [CW-1:0] ax, ay, az, input logic [RW-1:0] ar,
    input logic signed [CW-1:0] bx, by, bz, input logic [RW-1:0] br);
    in_word_t w;
    w.a_center_x = ax; w.a_center_y = ay; w.a_center_z = az; w.a_radius = ar;
    w.b_center_x = bx; w.b_center_y = by; w.b_center_z = bz; w.b_radius = br;
    return w;
  endfunction

  // Draw a coordinate: mostly near a random cluster, sometimes any value
  function automatic logic signed [CW-1:0] rand_coord(input logic signed [CW-1:0] base);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? CMAX : CMIN;
      2:       return base + $signed(32'($urandom_range(0, 2000)) - 1000);
      default: return base + $signed($urandom_range(0, 32'h3FFFF) - 32'h1FFFF);
    endcase
  endfunction

  function automatic logic [RW-1:0] rand_radius();
    case ($urandom_range(0, 5))
      0:       return RW'($urandom);
      1:       return $urandom_range(0, 1) ? RMAX : '0;
      2:       return RW'($urandom_range(0, 255));
      default: return RW'($urandom_range(0, 32'h3FFFF));
    endcase
  endfunction

  function automatic in_word_t random_pair();
    logic signed [CW-1:0] base;
    base = $urandom_range(0, 3) == 0 ? CW'($urandom) : CW'($urandom_range(0, 32'hFFFFF));
    return sphere_pair(rand_coord(base), rand_coord(base), rand_coord(base), rand_radius(),
                       rand_coord(base), rand_coord(base), rand_coord(base), rand_radius());
  endfunction

  // Directed rows; expected word typed in where obvious, else predicted
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input in_word_t w, input bit typed, input out_word_t want);
    directed_row_t r;
    r.w = w; r.typed = typed; r.want = want;
    directed_rows.push_back(r);
  endtask

  function automatic out_word_t sphere_word(
    input logic signed [CW-1:0] x, y, z, input logic [RW-1:0] r,
    input logic [1:0] kase, input logic sat);
    out_word_t o;
    o.merged_x = x; o.merged_y = y; o.merged_z = z; o.merged_radius = r;
    o.which_case = kase; o.saturated = sat;
    return o;
  endfunction

  task automatic build_directed();
    // equal spheres, zero everything: result is a
    add_row(sphere_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, sphere_word(0, 0, 0, 0, CASE_A, 0));
    // equal spheres at the extremes
    add_row(sphere_pair(CMAX, CMIN, CMAX, RMAX, CMAX, CMIN, CMAX, RMAX), 1,
            sphere_word(CMAX, CMIN, CMAX, RMAX, CASE_A, 0));
    add_row(sphere_pair(CMIN, CMIN, CMIN, 5, CMIN, CMIN, CMIN, 5), 1,
            sphere_word(CMIN, CMIN, CMIN, 5, CASE_A, 0));
    // b inside a
    add_row(sphere_pair(100, 200, 300, 1000, 110, 200, 300, 10), 1,
            sphere_word(100, 200, 300, 1000, CASE_A, 0));
    // a inside b
    add_row(sphere_pair(-5, -5, -5, 1, 0, 0, 0, RMAX), 1,
            sphere_word(0, 0, 0, RMAX, CASE_B, 0));
    // touching from inside: dist + rb == ra
    add_row(sphere_pair(0, 0, 0, 100, 30, 40, 0, 50), 1,
            sphere_word(0, 0, 0, 100, CASE_A, 0));
    // disjoint, simple axis: dist 100, R 60, center moves 50
    add_row(sphere_pair(0, 0, 0, 10, 100, 0, 0, 10), 1,
            sphere_word(50, 0, 0, 60, CASE_NEW, 0));
    add_row(sphere_pair(0, 0, 0, 0, 0, -7, 0, 0), 1,
            sphere_word(0, -3, 0, 3, CASE_NEW, 0));
    // opposite corners: radius and centers near saturation
    add_row(sphere_pair(CMIN, CMIN, CMIN, RMAX, CMAX, CMAX, CMAX, RMAX), 0, '0);
    add_row(sphere_pair(CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN, RMAX), 0, '0);
    add_row(sphere_pair(CMAX, 0, 0, 0, CMIN, 0, 0, 0), 0, '0);
    add_row(sphere_pair(CMIN, CMAX, 0, RMAX, CMAX, CMIN, 0, 0), 0, '0);
    add_row(sphere_pair(0, 0, 0, RMAX, 32'sh7FFF0000, 0, 0, RMAX), 0, '0);
    add_row(sphere_pair(CMAX, CMAX, CMAX, RMAX, CMAX - 1000, CMAX, CMAX, RMAX - 10), 0, '0);
    add_row(sphere_pair(-1, -1, -1, 1, 1, 1, 1, 1), 0, '0);
    add_row(sphere_pair(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 31'h2AAAAAAA,
                        32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0, 31'h55555555), 0, '0);
    add_row(sphere_pair(3, 4, 12, 0, 0, 0, 0, 0), 0, '0);
  endtask

  // Send one word after a random gap; record what it should produce
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    gap = $urandom_range(0, 13);
    // drop valid only if the next word is not back to back
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_spheres.push_back(typed ? want : merge_spheres(w));
  endtask

  // Sender: directed table, then random pairs, with long fill-up bursts
  initial begin
    directed_row_t r;
    @(posedge clk);
    wait (!rst);
    @(posedge clk);
    build_directed();
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_word(r.w, r.typed, r.want);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // before the receiver's hold-off is over, offer words back to back to fill the pipe
      if (!hold_off_done && n >= 100 && n < 300) begin
        item_valid <= 1'b1;
        item <= random_pair();
        @(posedge clk);
        while (item_stall) @(posedge clk);
        pending_spheres.push_back(merge_spheres(item));
      end else begin
        send_word(random_pair(), 0, '0);
      end
    end
    item_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off once the pipe is busy
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_off_done && pending_spheres.size() > 20) begin
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_done = 1'b1;
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        // stretch with no stalling at all
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // Check every accepted merged word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_spheres.size() == 0) begin
        $display("  merged word with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_spheres.pop_front();
        if (result.merged_x !== want.merged_x)
          report_mismatch("merged_x", result.merged_x, want.merged_x);
        if (result.merged_y !== want.merged_y)
          report_mismatch("merged_y", result.merged_y, want.merged_y);
        if (result.merged_z !== want.merged_z)
          report_mismatch("merged_z", result.merged_z, want.merged_z);
        if (result.merged_radius !== want.merged_radius)
          report_mismatch("merged_radius", result.merged_radius, want.merged_radius);
        if (result.which_case !== want.which_case)
          report_mismatch("which_case", result.which_case, want.which_case);
        if (result.saturated !== want.saturated)
          report_mismatch("saturated", result.saturated, want.saturated);
        if (want.which_case <= CASE_NEW) case_seen[want.which_case]++;
        if (want.saturated) sat_seen++;
      end
      words_checked++;
    end
  end

  // Reset, then wait for the pipeline to drain
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (sending_done);
    while (pending_spheres.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Merged %0d sphere pairs: %0d kept a, %0d kept b, %0d new spheres, %0d clamped.",
             words_checked, case_seen[0], case_seen[1], case_seen[2], sat_seen);
    if (mismatches == 0 && pending_spheres.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_isqrt.sv
hw/rtl/bsm_udiv.sv
hw/rtl/bounding_sphere_merge_unit.sv
sim/tb_bounding_sphere_merge_unit.sv
